[hw/rtl/cea_pkg.sv]
// ----------------------------------------------------------------------------
// cea_pkg: shared types and constants
// Opcodes, sequencer states and widths for the constant expression ALU.
// ----------------------------------------------------------------------------
package cea_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned OpWidth   = 5;
    localparam int unsigned CntWidth  = 7;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_MUL   = 5'd2,
        OP_DIV   = 5'd3,
        OP_MOD   = 5'd4,
        OP_POW   = 5'd5,
        OP_AND   = 5'd6,
        OP_OR    = 5'd7,
        OP_XOR   = 5'd8,
        OP_XNOR  = 5'd9,
        OP_SHL   = 5'd10,
        OP_SHR   = 5'd11,
        OP_SRA   = 5'd12,
        OP_LT    = 5'd13,
        OP_GT    = 5'd14,
        OP_LE    = 5'd15,
        OP_GE    = 5'd16,
        OP_EQ    = 5'd17,
        OP_NE    = 5'd18,
        OP_LAND  = 5'd19,
        OP_LOR   = 5'd20,
        OP_NEG   = 5'd21,
        OP_PLUS  = 5'd22,
        OP_INV   = 5'd23,
        OP_LNOT  = 5'd24
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_POW,
        ST_DONE
    } state_t;

    // one step of the shared 16x64 partial product unit
    typedef struct packed {
        logic [DataWidth-1:0] a;
        logic [15:0]          b;
    } mul_step_t;

endpackage

[hw/rtl/cea_mul_seq.sv]
// ----------------------------------------------------------------------------
// cea_mul_seq: shared multiplier
// Wrapping 64x64 multiply, low 64 bits, sixteen bits of the second operand
// per cycle.
// ----------------------------------------------------------------------------
module cea_mul_seq
    import cea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DataWidth-1:0] a,
    input  logic [DataWidth-1:0] b,
    output logic                 done,
    output logic [DataWidth-1:0] product
);

    logic [DataWidth-1:0] a_reg, a_next;
    logic [DataWidth-1:0] b_reg, b_next;
    logic [DataWidth-1:0] acc_reg, acc_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    mul_step_t            step;
    logic [DataWidth-1:0] part;

    assign step.a = a_reg;
    assign step.b = b_reg[15:0];
    assign part   = DataWidth'(step.a * {{(DataWidth-16){1'b0}}, step.b});

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + part;
            a_next   = a_reg << 16;
            b_next   = b_reg >> 16;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[hw/rtl/constant_expression_alu_unit.sv]
// ----------------------------------------------------------------------------
// constant_expression_alu_unit: signed 64-bit integer ALU
// One operation per beat. Simple operations give their result beat in the
// cycle after acceptance. Multiply runs on the shared multiplier; divide and
// modulo run a radix-2 restoring loop; power runs square-and-multiply on
// the same shared multiplier, one exponent bit at a time up to the top set bit.
// Input stall stays high from acceptance until the result beat has been taken,
// so no new beat is taken before then.
// ----------------------------------------------------------------------------
module constant_expression_alu_unit
    import cea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OpWidth-1:0]   op,
    input  logic signed [DataWidth-1:0] left_operand,
    input  logic signed [DataWidth-1:0] right_operand,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [DataWidth-1:0] value,
    output logic                 valid_res
);

    state_t               state_reg, state_next;
    logic [OpWidth-1:0]   op_reg, op_next;
    logic [DataWidth-1:0] a_reg, a_next;
    logic [DataWidth-1:0] b_reg, b_next;
    logic [DataWidth-1:0] rem_reg, rem_next;
    logic [DataWidth-1:0] acc_reg, acc_next;
    logic [DataWidth-1:0] val_reg, val_next;
    logic                 ok_reg, ok_next;
    logic                 sq_reg, sq_next;
    logic                 neg_q_reg, neg_q_next;
    logic                 neg_r_reg, neg_r_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;

    logic                 mul_start;
    logic [DataWidth-1:0] mul_a, mul_b, mul_p;
    logic                 mul_done;

    logic [DataWidth-1:0] ua, ub, sh_val;
    logic [DataWidth:0]   trial;
    logic [DataWidth-1:0] rem_sh;
    logic                 big_shift, lt_ab, lt_ba;
    logic [5:0]           sh;

    cea_mul_seq u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign ua        = left_operand[DataWidth-1] ? -left_operand : left_operand;
    assign ub        = right_operand[DataWidth-1] ? -right_operand : right_operand;
    assign big_shift = right_operand[DataWidth-1] || (right_operand[DataWidth-2:6] != '0);
    assign sh        = right_operand[5:0];
    assign lt_ab     = left_operand < right_operand;
    assign lt_ba     = right_operand < left_operand;
    assign rem_sh    = {rem_reg[DataWidth-2:0], a_reg[DataWidth-1]};
    assign trial     = {1'b0, rem_sh} - {1'b0, b_reg};

    always_comb
    begin
        sh_val = '0;
        case (op)
            OP_SHL: sh_val = big_shift ? '0 : left_operand << sh;
            OP_SHR: sh_val = big_shift ? '0 : left_operand >> sh;
            default:
                sh_val = big_shift ? {DataWidth{left_operand[DataWidth-1]}}
                                   : DataWidth'(left_operand >>> sh);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        val_next   = val_reg;
        ok_next    = ok_reg;
        sq_next    = sq_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        cnt_next   = cnt_reg;
        mul_start  = 1'b0;
        mul_a      = acc_reg;
        mul_b      = a_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    ok_next    = 1'b1;
                    val_next   = '0;
                    state_next = ST_DONE;
                    unique case (op) inside
                        OP_ADD:  val_next = left_operand + right_operand;
                        OP_SUB:  val_next = left_operand - right_operand;
                        OP_MUL:
                        begin
                            mul_start  = 1'b1;
                            mul_a      = left_operand;
                            mul_b      = right_operand;
                            state_next = ST_MUL;
                        end
                        OP_DIV, OP_MOD:
                        begin
                            if (right_operand == '0)
                                ok_next = 1'b0;
                            else
                            begin
                                a_next     = ua;
                                b_next     = ub;
                                rem_next   = '0;
                                cnt_next   = '0;
                                neg_q_next = left_operand[DataWidth-1] ^
                                             right_operand[DataWidth-1];
                                neg_r_next = left_operand[DataWidth-1];
                                state_next = ST_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (right_operand[DataWidth-1])
                                ok_next = 1'b0;
                            else
                            begin
                                a_next     = left_operand;
                                b_next     = right_operand;
                                acc_next   = {{(DataWidth-1){1'b0}}, 1'b1};
                                sq_next    = 1'b0;
                                state_next = ST_POW;
                            end
                        end
                        OP_AND:  val_next = left_operand & right_operand;
                        OP_OR:   val_next = left_operand | right_operand;
                        OP_XOR:  val_next = left_operand ^ right_operand;
                        OP_XNOR: val_next = ~(left_operand ^ right_operand);
                        OP_SHL, OP_SHR, OP_SRA: val_next = sh_val;
                        OP_LT:   val_next = DataWidth'(lt_ab);
                        OP_GT:   val_next = DataWidth'(lt_ba);
                        OP_LE:   val_next = DataWidth'(!lt_ba);
                        OP_GE:   val_next = DataWidth'(!lt_ab);
                        OP_EQ:   val_next = DataWidth'(left_operand == right_operand);
                        OP_NE:   val_next = DataWidth'(left_operand != right_operand);
                        OP_LAND: val_next = DataWidth'((left_operand != '0) &&
                                                       (right_operand != '0));
                        OP_LOR:  val_next = DataWidth'((left_operand != '0) ||
                                                       (right_operand != '0));
                        OP_NEG:  val_next = -left_operand;
                        OP_PLUS: val_next = left_operand;
                        OP_INV:  val_next = ~left_operand;
                        OP_LNOT: val_next = DataWidth'(left_operand == '0);
                        default: ok_next = 1'b0;
                    endcase
                end
            end
            ST_DIV:
            begin
                a_next = {a_reg[DataWidth-2:0], ~trial[DataWidth]};
                rem_next = trial[DataWidth] ? rem_sh : trial[DataWidth-1:0];
                cnt_next = cnt_reg + CntWidth'(1);
                if (cnt_reg == CntWidth'(DataWidth - 1))
                begin
                    if (op_reg == OP_DIV)
                        val_next = neg_q_reg ? -a_next : a_next;
                    else
                        val_next = neg_r_reg ? -rem_next : rem_next;
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    val_next   = mul_p;
                    state_next = ST_DONE;
                end
            end
            ST_POW:
            begin
                // alternate: multiply acc by base if bit set, then square base
                if (!sq_reg)
                begin
                    if (b_reg == '0)
                    begin
                        val_next   = acc_reg;
                        state_next = ST_DONE;
                    end
                    else if (b_reg[0])
                    begin
                        mul_start = 1'b1;
                        mul_a     = acc_reg;
                        mul_b     = a_reg;
                        sq_next   = 1'b1;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        mul_start = 1'b1;
                        mul_a     = a_reg;
                        mul_b     = a_reg;
                        sq_next   = 1'b1;
                        cnt_next  = CntWidth'(1);
                    end
                end
                else if (mul_done)
                begin
                    if (cnt_reg == '0)
                    begin
                        acc_next  = mul_p;
                        mul_start = 1'b1;
                        mul_a     = a_reg;
                        mul_b     = a_reg;
                        cnt_next  = CntWidth'(1);
                    end
                    else
                    begin
                        a_next  = mul_p;
                        b_next  = b_reg >> 1;
                        sq_next = 1'b0;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        val_reg   <= val_next;
        ok_reg    <= ok_next;
        sq_reg    <= sq_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        cnt_reg   <= cnt_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign value     = ok_reg ? val_reg : '0;
    assign valid_res = ok_reg;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: constant expression ALU check
// Drives operations through the input channel, predicts each answer from
// a behavioural 64-bit ALU model and compares every result beat against the
// oldest prediction, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench
    import cea_pkg::*;
();

    localparam logic [OpWidth-1:0] OP_BAD_LO = 5'd25;
    localparam logic [OpWidth-1:0] OP_BAD_HI = 5'd31;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

    typedef struct packed {
        logic [63:0] value;
        logic        valid_res;
    } alu_answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [OpWidth-1:0] op;
    logic signed [DataWidth-1:0] left_operand;
    logic signed [DataWidth-1:0] right_operand;
    logic out_valid;
    logic out_stall;
    logic signed [DataWidth-1:0] value;
    logic valid_res;

    alu_answer_t answers_due[$];
    int errors;
    int beats_sent;
    int beats_checked;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;

    constant_expression_alu_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .left_operand(left_operand), .right_operand(right_operand),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .valid_res(valid_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [63:0] wrap_power(logic [63:0] base, logic [63:0] ex);
        logic [63:0] acc;
        acc = 64'd1;
        while (ex != 0)
        begin
            if (ex[0])
                acc = acc * base;
            base = base * base;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    function automatic alu_answer_t alu_predict(logic [4:0] code, logic [63:0] a,
                                                logic [63:0] b);
        alu_answer_t r;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] rem;
        logic big;
        logic [5:0] sh;
        big = b[63] || (b >= 64);
        sh = b[5:0];
        r.value = '0;
        r.valid_res = 1'b1;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        case (code) inside
            OP_ADD:  r.value = a + b;
            OP_SUB:  r.value = a - b;
            OP_MUL:  r.value = a * b;
            OP_DIV, OP_MOD:
            begin
                if (b == 0)
                    r.valid_res = 1'b0;
                else
                begin
                    q = ma / mb;
                    rem = ma % mb;
                    if (code == OP_DIV)
                        r.value = (a[63] != b[63]) ? -q : q;
                    else
                        r.value = a[63] ? -rem : rem;
                end
            end
            OP_POW:
            begin
                if (b[63])
                    r.valid_res = 1'b0;
                else
                    r.value = wrap_power(a, b);
            end
            OP_AND:  r.value = a & b;
            OP_OR:   r.value = a | b;
            OP_XOR:  r.value = a ^ b;
            OP_XNOR: r.value = ~(a ^ b);
            OP_SHL:  r.value = big ? 64'd0 : a << sh;
            OP_SHR:  r.value = big ? 64'd0 : a >> sh;
            OP_SRA:  r.value = big ? {64{a[63]}} : 64'($signed(a) >>> sh);
            OP_LT:   r.value = 64'($signed(a) < $signed(b));
            OP_GT:   r.value = 64'($signed(a) > $signed(b));
            OP_LE:   r.value = 64'($signed(a) <= $signed(b));
            OP_GE:   r.value = 64'($signed(a) >= $signed(b));
            OP_EQ:   r.value = 64'(a == b);
            OP_NE:   r.value = 64'(a != b);
            OP_LAND: r.value = 64'(a != 0 && b != 0);
            OP_LOR:  r.value = 64'(a != 0 || b != 0);
            OP_NEG:  r.value = -a;
            OP_PLUS: r.value = a;
            OP_INV:  r.value = ~a;
            OP_LNOT: r.value = 64'(a == 0);
            default: r.valid_res = 1'b0;
        endcase
        if (!r.valid_res)
            r.value = '0;
        return r;
    endfunction

    task automatic send_beat(logic [4:0] code, logic [63:0] a, logic [63:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        left_operand <= a;
        right_operand <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        answers_due.push_back(alu_predict(code, a, b));
        beats_sent++;
    endtask

    // receiver side: stall at random, or hold off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        alu_answer_t exp_ans;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (answers_due.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                exp_ans = answers_due.pop_front();
                if (value !== exp_ans.value)
                begin
                    $error("value expected %h got %h", exp_ans.value, value);
                    errors++;
                end
                if (valid_res !== exp_ans.valid_res)
                begin
                    $error("valid_res expected %b got %b", exp_ans.valid_res, valid_res);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(7))
            0: return MIN64;
            1: return MAX64;
            2: return 64'($urandom_range(5)) - 64'd2;
            3: return {32'd0, $urandom()} >> $urandom_range(31);
            4: return -{32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [63:0] pick_right(logic [4:0] code);
        if (code == OP_POW && $urandom_range(9) != 0)
            return 64'($urandom_range(40)) + (($urandom_range(7) == 0) ? 64'd0 : 64'd0);
        if ((code == OP_SHL || code == OP_SHR || code == OP_SRA) && $urandom_range(3) != 0)
            return 64'($urandom_range(70));
        if ((code == OP_DIV || code == OP_MOD) && $urandom_range(9) == 0)
            return 64'd0;
        return pick_operand();
    endfunction

    task automatic test_directed();
        logic [4:0] c;
        send_beat(OP_DIV, MIN64, -64'd1);
        send_beat(OP_MOD, MIN64, -64'd1);
        send_beat(OP_DIV, 64'd7, 64'd0);
        send_beat(OP_MOD, -64'd7, 64'd2);
        send_beat(OP_DIV, -64'd7, 64'd2);
        send_beat(OP_POW, 64'd0, 64'd0);
        send_beat(OP_POW, 64'd3, -64'd1);
        send_beat(OP_POW, 64'd3, MAX64);
        send_beat(OP_SHL, MAX64, 64'd64);
        send_beat(OP_SHR, MIN64, -64'd1);
        send_beat(OP_SRA, MIN64, 64'd100);
        send_beat(OP_SRA, MIN64, 64'd63);
        send_beat(OP_ADD, MAX64, 64'd1);
        send_beat(OP_MUL, MIN64, -64'd1);
        send_beat(OP_NEG, MIN64, MAX64);
        send_beat(OP_BAD_LO, 64'd1, 64'd1);
        send_beat(OP_BAD_HI, -64'd1, -64'd1);
        for (int i = 0; i <= 24; i += 3)
        begin
            c = 5'(i);
            send_beat(c, MAX64, MIN64);
        end
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        logic [4:0] c;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            c = ($urandom_range(19) == 0) ? 5'($urandom_range(25, 31))
                                          : 5'($urandom_range(24));
            send_beat(c, pick_operand(), pick_right(c));
        end
    endtask

    task automatic test_hold_off();
        hold_off = 1'b1;
        fork
            begin
                for (int i = 0; i < 8; i++)
                    send_beat(5'($urandom_range(24)), pick_operand(), 64'($urandom_range(63)));
            end
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = '0;
        left_operand = '0;
        right_operand = '0;
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400, 0, 0);
        test_random(400, 82, 0);
        test_random(400, 0, 82);
        test_random(392, 10, 10);
        test_hold_off();
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Sent %0d operations, checked %0d result beats", beats_sent, beats_checked);
        $display("Covered all opcodes, edge operands and four idling patterns");
        if (errors == 0 && answers_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
